// ----- rtl/core/quaternion_to_euler_degrees_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angle unit
// Overlapping and non-overlapping implication checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_DEGREES_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_DEGREES_UNIT_ASSERT_SVH

// Same-cycle implication
`define QTE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, angle constants and the arctangent table of the unit.
// ----------------------------------------------------------------------------
package qte_pkg;

  // Defaults of the top-level parameters
  localparam int COMPONENT_WIDTH_DEF     = 16;
  localparam int ANGLE_FRACTION_BITS_DEF = 7;
  localparam int CORDIC_STEPS_DEF        = 16;
  localparam int CORDIC_MAX_STEPS        = 32;

  // Datapath widths
  localparam int CIN_W   = 16;  // component width used by the products
  localparam int SQ_W    = 31;  // square of a component
  localparam int PR_W    = 32;  // signed cross product
  localparam int N_W     = 33;  // squared norm
  localparam int S_W     = 34;  // signed pitch sine term
  localparam int XY_W    = 35;  // signed atan2 operand
  localparam int MAG_W   = 34;  // atan2 operand magnitude
  localparam int CX_W    = 33;  // rotation registers
  localparam int ANG_W   = 25;  // angle accumulator, degrees with 16 fraction bits
  localparam int DEGM_W  = 24;  // angle magnitude up to 180 degrees
  localparam int ACC_FRAC = 16;
  localparam int NORM_POS = 29; // leading one of the larger operand after scaling
  localparam int POS_W   = 6;
  localparam int RAD_W   = 64;  // square-root radicand
  localparam int ROOT_W  = 32;
  localparam int SQRT_STEPS = 32;

  // Result fields
  localparam int PITCH_W     = 15;
  localparam int ANGLE_W     = 16;
  localparam int OUT_TDATA_W = 48;

  // Pipeline shape
  localparam int FRONT_STAGES = 5;
  localparam int CORDIC_EXTRA = 5;

  localparam logic signed [ANG_W-1:0] DEG90  = 25'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180 = 25'sd11796480;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_MAX_STEPS] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
    25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
    25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
    25'sd917,     25'sd458,     25'sd229,    25'sd115,
    25'sd57,      25'sd29,      25'sd14,     25'sd7,
    25'sd4,       25'sd2,       25'sd1,      25'sd0,
    25'sd0,       25'sd0,       25'sd0,      25'sd0,
    25'sd0,       25'sd0,       25'sd0,      25'sd0
  };

  typedef struct packed {
    logic lim;   // pitch sine reached the norm
    logic sneg;  // pitch sine negative
  } pitch_side_t;

endpackage

// ----- rtl/core/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in degrees, rounded to the output
// fraction, one operand pair per cycle while en is high.
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int STEPS     = qte_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS = qte_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [qte_pkg::XY_W-1:0]   x_in,
  input  logic signed [qte_pkg::XY_W-1:0]   y_in,
  output logic [qte_pkg::ANGLE_W-1:0]       angle
);

  localparam int SH = qte_pkg::ACC_FRAC - FRAC_BITS;
  localparam logic [qte_pkg::ANG_W-1:0] HALF = qte_pkg::ANG_W'((1 << SH) >> 1);

  logic [qte_pkg::MAG_W-1:0] ux1, uy1, ux2, uy2, orv, nx, ny;
  logic                      xn1, yn1, xn2, yn2, nz2;
  logic [qte_pkg::POS_W-1:0] p2, pos;

  logic signed [qte_pkg::CX_W-1:0]  cx [STEPS+1];
  logic signed [qte_pkg::CX_W-1:0]  cy [STEPS+1];
  logic signed [qte_pkg::ANG_W-1:0] z  [STEPS+1];
  logic                             xn_s [STEPS+1];
  logic                             yn_s [STEPS+1];
  logic                             nz_s [STEPS+1];

  logic signed [qte_pkg::ANG_W-1:0] zc;
  logic [qte_pkg::DEGM_W-1:0]       mag, mag_next;
  logic                             sgn;
  logic [qte_pkg::ANG_W-1:0]        rnd, res;

  // Take magnitudes and quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      ux1 <= qte_pkg::MAG_W'(x_in[qte_pkg::XY_W-1] ? -x_in : x_in);
      uy1 <= qte_pkg::MAG_W'(y_in[qte_pkg::XY_W-1] ? -y_in : y_in);
      xn1 <= x_in[qte_pkg::XY_W-1];
      yn1 <= y_in[qte_pkg::XY_W-1];
    end
  end

  // Find the leading one of both magnitudes
  always_comb begin
    orv = ux1 | uy1;
    pos = '0;
    for (int b = 0; b < qte_pkg::MAG_W; b++) begin
      if (orv[b]) pos = qte_pkg::POS_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux2 <= ux1;
      uy2 <= uy1;
      p2  <= pos;
      nz2 <= |orv;
      xn2 <= xn1;
      yn2 <= yn1;
    end
  end

  // Scale both so the larger sits just below 2^30
  always_comb begin
    if (p2 > qte_pkg::POS_W'(qte_pkg::NORM_POS)) begin
      nx = ux2 >> (p2 - qte_pkg::POS_W'(qte_pkg::NORM_POS));
      ny = uy2 >> (p2 - qte_pkg::POS_W'(qte_pkg::NORM_POS));
    end else begin
      nx = ux2 << (qte_pkg::POS_W'(qte_pkg::NORM_POS) - p2);
      ny = uy2 << (qte_pkg::POS_W'(qte_pkg::NORM_POS) - p2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]   <= qte_pkg::CX_W'(nx);
      cy[0]   <= qte_pkg::CX_W'(ny);
      z[0]    <= '0;
      xn_s[0] <= xn2;
      yn_s[0] <= yn2;
      nz_s[0] <= nz2;
    end
  end

  // One rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] >= 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          z[i+1]  <= z[i] + qte_pkg::ATAN_TAB[i];
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          z[i+1]  <= z[i] - qte_pkg::ATAN_TAB[i];
        end
        xn_s[i+1] <= xn_s[i];
        yn_s[i+1] <= yn_s[i];
        nz_s[i+1] <= nz_s[i];
      end
    end
  end

  // Clamp to the first quadrant and map back
  always_comb begin
    if (z[STEPS] < 0) begin
      zc = '0;
    end else if (z[STEPS] > qte_pkg::DEG90) begin
      zc = qte_pkg::DEG90;
    end else begin
      zc = z[STEPS];
    end
    if (!nz_s[STEPS]) begin
      mag_next = '0;
    end else if (xn_s[STEPS]) begin
      mag_next = qte_pkg::DEGM_W'(qte_pkg::DEG180 - zc);
    end else begin
      mag_next = qte_pkg::DEGM_W'(zc);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= mag_next;
      sgn <= yn_s[STEPS];
    end
  end

  // Round half up on the magnitude, then apply the sign
  always_comb begin
    rnd = (qte_pkg::ANG_W'(mag) + HALF) >> SH;
    res = sgn ? -rnd : rnd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= res[qte_pkg::ANGLE_W-1:0];
    end
  end

endmodule

// ----- rtl/core/quaternion_to_euler_degrees_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_unit
// Quaternion in, pitch, yaw and roll in degrees out, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one quaternion per cycle while s_axis_tready is high and returns one result
// per request, in order. From input acceptance to the output register the path runs
// through five stages of products and sums, a 32-stage square-root pipeline for the
// pitch cosine, then a vectoring CORDIC with one stage per iteration plus scaling and
// rounding stages. Yaw and roll run their CORDICs early and wait in a delay line. The
// pipeline only holds when its last stage is full and the output register is still
// waiting.
module quaternion_to_euler_degrees_unit #(
  parameter int COMPONENT_WIDTH     = qte_pkg::COMPONENT_WIDTH_DEF,
  parameter int ANGLE_FRACTION_BITS = qte_pkg::ANGLE_FRACTION_BITS_DEF,
  parameter int CORDIC_STEPS        = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, zero padding
  input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pitch_deg, yaw_deg, roll_deg, zero padding
  output logic [qte_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // pitch_at_limit
  output logic m_axis_tuser
);

  localparam int CL       = CORDIC_STEPS + qte_pkg::CORDIC_EXTRA;
  localparam int PRE      = qte_pkg::FRONT_STAGES + qte_pkg::SQRT_STEPS;
  localparam int LAT      = PRE + CL;
  localparam int YR_DLY   = PRE - 3;
  localparam int SIDE_DLY = LAT - 5;
  localparam logic signed [qte_pkg::ANG_W-1:0] P90_FULL =
    qte_pkg::ANG_W'(90) <<< ANGLE_FRACTION_BITS;
  localparam logic signed [qte_pkg::ANG_W-1:0] N90_FULL = -P90_FULL;

  logic en, out_load;
  logic [LAT:1] v;

  logic signed [qte_pkg::CIN_W-1:0] comp [4];
  logic signed [qte_pkg::PR_W-1:0]  prod [10];

  logic [qte_pkg::SQ_W-1:0]        sq1 [4];
  logic signed [qte_pkg::PR_W-1:0] wx1, yz1, wy1, xz1, wz1, xy1;

  logic [qte_pkg::N_W-1:0]         n2;
  logic signed [qte_pkg::S_W-1:0]  s2;
  logic signed [qte_pkg::XY_W-1:0] yaw_y2, yaw_x2, roll_y2, roll_x2;

  logic [qte_pkg::N_W-1:0] a3, n3;
  logic                    sneg3;

  logic [qte_pkg::ROOT_W-1:0]      m4c, ah4c, dif4;
  logic [qte_pkg::ROOT_W:0]        sum4;
  logic signed [qte_pkg::XY_W-1:0] ys4;
  qte_pkg::pitch_side_t            side4;

  logic [qte_pkg::RAD_W-1:0]       rd [qte_pkg::SQRT_STEPS+1];
  logic [qte_pkg::RAD_W-1:0]       rt [qte_pkg::SQRT_STEPS+1];
  logic signed [qte_pkg::XY_W-1:0] ys_d [qte_pkg::SQRT_STEPS+1];

  qte_pkg::pitch_side_t side_d [SIDE_DLY+1];
  logic [qte_pkg::ANGLE_W-1:0] yaw_c, roll_c, pitch_c;
  logic [qte_pkg::ANGLE_W-1:0] yaw_d [YR_DLY+1];
  logic [qte_pkg::ANGLE_W-1:0] roll_d [YR_DLY+1];
  logic signed [qte_pkg::XY_W-1:0] pitch_x;

  logic [qte_pkg::PITCH_W-1:0] pitch_q, pitch_next;
  logic [qte_pkg::ANGLE_W-1:0] yaw_q, roll_q;
  logic                        flag_q;

  // Advance unless a finished result has nowhere to go
  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign en            = !v[LAT] || out_load;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-1:1], s_axis_tvalid};
    end
  end

  // Reduce each component to its top 16 bits, or sign-extend a narrower one to 16 bits
  for (genvar k = 0; k < 4; k++) begin : g_in
    logic [COMPONENT_WIDTH-1:0] raw;
    assign raw = s_axis_tdata[k*COMPONENT_WIDTH +: COMPONENT_WIDTH];
    if (COMPONENT_WIDTH >= qte_pkg::CIN_W) begin : g_top
      assign comp[k] = raw[COMPONENT_WIDTH-1 -: qte_pkg::CIN_W];
    end else begin : g_ext
      assign comp[k] = {{(qte_pkg::CIN_W-COMPONENT_WIDTH){raw[COMPONENT_WIDTH-1]}}, raw};
    end
  end

  // Squares and cross products
  always_comb begin
    prod[0] = comp[0] * comp[0];
    prod[1] = comp[1] * comp[1];
    prod[2] = comp[2] * comp[2];
    prod[3] = comp[3] * comp[3];
    prod[4] = comp[0] * comp[1];
    prod[5] = comp[2] * comp[3];
    prod[6] = comp[0] * comp[2];
    prod[7] = comp[1] * comp[3];
    prod[8] = comp[0] * comp[3];
    prod[9] = comp[1] * comp[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) sq1[k] <= prod[k][qte_pkg::SQ_W-1:0];
      wx1 <= prod[4];
      yz1 <= prod[5];
      wy1 <= prod[6];
      xz1 <= prod[7];
      wz1 <= prod[8];
      xy1 <= prod[9];
    end
  end

  // Norm, pitch sine and the atan2 operands of yaw and roll
  always_ff @(posedge clk) begin
    if (en) begin
      n2 <= qte_pkg::N_W'(sq1[0]) + qte_pkg::N_W'(sq1[1])
          + qte_pkg::N_W'(sq1[2]) + qte_pkg::N_W'(sq1[3]);
      s2 <= (qte_pkg::S_W'(wx1) - qte_pkg::S_W'(yz1)) <<< 1;
      yaw_y2  <= (qte_pkg::XY_W'(wy1) + qte_pkg::XY_W'(xz1)) <<< 1;
      roll_y2 <= (qte_pkg::XY_W'(wz1) + qte_pkg::XY_W'(xy1)) <<< 1;
      yaw_x2  <= $signed(qte_pkg::XY_W'(sq1[0])) + $signed(qte_pkg::XY_W'(sq1[3]))
               - $signed(qte_pkg::XY_W'(sq1[1])) - $signed(qte_pkg::XY_W'(sq1[2]));
      roll_x2 <= $signed(qte_pkg::XY_W'(sq1[0])) + $signed(qte_pkg::XY_W'(sq1[2]))
               - $signed(qte_pkg::XY_W'(sq1[1])) - $signed(qte_pkg::XY_W'(sq1[3]));
    end
  end

  // Magnitude of the sine term
  always_ff @(posedge clk) begin
    if (en) begin
      a3    <= qte_pkg::N_W'(s2[qte_pkg::S_W-1] ? -s2 : s2);
      n3    <= n2;
      sneg3 <= s2[qte_pkg::S_W-1];
    end
  end

  // Halve a full-scale norm, form the cosine factors, detect the limit
  always_comb begin
    m4c  = n3[qte_pkg::N_W-1] ? n3[qte_pkg::N_W-1:1] : n3[qte_pkg::ROOT_W-1:0];
    ah4c = n3[qte_pkg::N_W-1] ? a3[qte_pkg::N_W-1:1] : a3[qte_pkg::ROOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dif4       <= m4c - ah4c;
      sum4       <= (qte_pkg::ROOT_W+1)'(m4c) + (qte_pkg::ROOT_W+1)'(ah4c);
      ys4        <= sneg3 ? -qte_pkg::XY_W'(ah4c) : qte_pkg::XY_W'(ah4c);
      side4.lim  <= (a3 >= n3) && (n3 != '0);
      side4.sneg <= sneg3;
    end
  end

  // Radicand n^2 - s^2
  always_ff @(posedge clk) begin
    if (en) begin
      rd[0]   <= qte_pkg::RAD_W'(dif4 * sum4);
      rt[0]   <= '0;
      ys_d[0] <= ys4;
    end
  end

  // Square root, one result bit per stage
  for (genvar j = 0; j < qte_pkg::SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [qte_pkg::RAD_W-1:0] ONE_BIT =
      qte_pkg::RAD_W'(1) << (qte_pkg::RAD_W - 2 - 2*j);
    logic [qte_pkg::RAD_W-1:0] trial;
    assign trial = rt[j] + ONE_BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rd[j] >= trial) begin
          rd[j+1] <= rd[j] - trial;
          rt[j+1] <= (rt[j] >> 1) + ONE_BIT;
        end else begin
          rd[j+1] <= rd[j];
          rt[j+1] <= rt[j] >> 1;
        end
        ys_d[j+1] <= ys_d[j];
      end
    end
  end

  assign pitch_x = qte_pkg::XY_W'(rt[qte_pkg::SQRT_STEPS][qte_pkg::ROOT_W-1:0]);

  qte_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(ANGLE_FRACTION_BITS)) u_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  (pitch_x),
    .y_in  (ys_d[qte_pkg::SQRT_STEPS]),
    .angle (pitch_c)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(ANGLE_FRACTION_BITS)) u_yaw (
    .clk   (clk),
    .en    (en),
    .x_in  (yaw_x2),
    .y_in  (yaw_y2),
    .angle (yaw_c)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(ANGLE_FRACTION_BITS)) u_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (roll_x2),
    .y_in  (roll_y2),
    .angle (roll_c)
  );

  // Hold yaw, roll and the pitch flags until the pitch angle catches up
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side4;
      for (int k = 1; k <= SIDE_DLY; k++) side_d[k] <= side_d[k-1];
      yaw_d[0]  <= yaw_c;
      roll_d[0] <= roll_c;
      for (int k = 1; k <= YR_DLY; k++) begin
        yaw_d[k]  <= yaw_d[k-1];
        roll_d[k] <= roll_d[k-1];
      end
    end
  end

  // Clamp pitch at the limit
  always_comb begin
    if (side_d[SIDE_DLY].lim) begin
      pitch_next = side_d[SIDE_DLY].sneg ? N90_FULL[qte_pkg::PITCH_W-1:0]
                                         : P90_FULL[qte_pkg::PITCH_W-1:0];
    end else begin
      pitch_next = pitch_c[qte_pkg::PITCH_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= v[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pitch_q <= pitch_next;
      yaw_q   <= yaw_d[YR_DLY];
      roll_q  <= roll_d[YR_DLY];
      flag_q  <= side_d[SIDE_DLY].lim;
    end
  end

  assign m_axis_tdata = {1'b0, roll_q, yaw_q, pitch_q};
  assign m_axis_tuser = flag_q;

endmodule

// ----- rtl/core/qte_checker.sv -----
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks of the quaternion to Euler angle unit, bound to the top.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_degrees_unit_assert.svh"

module qte_checker #(
  parameter int ANGLE_FRACTION_BITS = qte_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [qte_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  localparam logic signed [qte_pkg::ANG_W-1:0] P90_FULL =
    qte_pkg::ANG_W'(90) <<< ANGLE_FRACTION_BITS;
  localparam logic signed [qte_pkg::ANG_W-1:0] N90_FULL = -P90_FULL;

  logic [qte_pkg::PITCH_W-1:0] pitch;
  assign pitch = m_axis_tdata[qte_pkg::PITCH_W-1:0];

  // Hold a stalled result
  `QTE_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // A taken output always frees the input side
  `QTE_ASSERT_IMPLY(a_ready_follows, clk, rst, m_axis_tready, s_axis_tready, "input stalled while output drains")

  // A clamped pitch reads exactly plus or minus ninety degrees
  `QTE_ASSERT_IMPLY(a_limit_pitch, clk, rst, m_axis_tvalid && m_axis_tuser, pitch == P90_FULL[qte_pkg::PITCH_W-1:0] || pitch == N90_FULL[qte_pkg::PITCH_W-1:0], "clamped pitch not at ninety degrees")

  // Padding bit stays clear
  `QTE_ASSERT_IMPLY(a_pad_zero, clk, rst, m_axis_tvalid, !m_axis_tdata[qte_pkg::OUT_TDATA_W-1], "output padding set")

endmodule

bind quaternion_to_euler_degrees_unit qte_checker #(
  .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
) u_qte_checker (.*);
